// File: src/ddlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddlp_pkg;

  typedef enum logic [3:0] {
    PH_LINK_LO,
    PH_LINK_HI,
    PH_BLK_LO,
    PH_BLK_HI,
    PH_TEXT0,
    PH_LEAD,
    PH_NAME,
    PH_POSTNAME,
    PH_POSTSTAR,
    PH_TYPE0,
    PH_TYPE1,
    PH_TYPE2,
    PH_LOCK,
    PH_REST,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [3:0] T_HEADER    = 4'd0;
  localparam logic [3:0] T_UNKNOWN   = 4'd1;
  localparam logic [3:0] T_TYPE_BASE = 4'd2;
  localparam logic [3:0] T_BFREE     = 4'd7;
  localparam logic [3:0] T_OTHER     = 4'd8;

  localparam int unsigned NUM_TYPES = 5;

  localparam logic [7:0] HEADER_MARK = 8'h12;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_LOCK     = 8'h3c;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0d;

  localparam logic [23:0] BLOCK_DATA_BYTES = 24'd254;

  typedef logic [7:0] type_name_t [3];

  // file type names in type code order, starting at T_TYPE_BASE
  localparam type_name_t TYPE_NAMES [NUM_TYPES] = '{
    '{8'h44, 8'h45, 8'h4c},
    '{8'h53, 8'h45, 8'h51},
    '{8'h50, 8'h52, 8'h47},
    '{8'h55, 8'h53, 8'h52},
    '{8'h52, 8'h45, 8'h4c}
  };

  typedef struct packed {
    phase_t                 phase;
    logic                   link_low_nonzero;
    logic [15:0]            line_blocks;
    logic [3:0]             line_type;
    logic                   unclosed_mark;
    logic                   lock_mark;
    logic [NUM_TYPES-1:0]   type_match_mask;
    logic [7:0]             name_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:            PH_LINK_LO,
    link_low_nonzero: 1'b0,
    line_blocks:      16'd0,
    line_type:        T_OTHER,
    unclosed_mark:    1'b0,
    lock_mark:        1'b0,
    type_match_mask:  '1,
    name_count:       8'd0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] block_count;
    logic [23:0] size_bytes;
    logic [3:0]  entry_type;
    logic        not_closed;
    logic        read_only;
    logic [7:0]  name_length;
    logic        is_last;
  } result_t;

endpackage
`default_nettype wire

// File: src/ddlp_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ddlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// File: src/ddlp_rec_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ddlp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [15:0] block_count;
  logic [23:0] size_bytes;
  logic [3:0]  entry_type;
  logic        not_closed;
  logic        read_only;
  logic [7:0]  name_length;
  logic        is_last;

  modport source (
    output valid, output kind, output name_char, output block_count,
    output size_bytes, output entry_type, output not_closed, output read_only,
    output name_length, output is_last, input ready
  );
  modport sink (
    input valid, input kind, input name_char, input block_count,
    input size_bytes, input entry_type, input not_closed, input read_only,
    input name_length, input is_last, output ready
  );
endinterface
`default_nettype wire

// File: src/ddlp_step.sv
`timescale 1ns / 1ps
`default_nettype none
module ddlp_step (
  input  ddlp_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  output ddlp_pkg::state_t  nxt,
  output logic              res_valid,
  output ddlp_pkg::result_t res
);
  import ddlp_pkg::*;

  state_t               st;
  logic                 is_space;
  logic [NUM_TYPES-1:0] mism0;
  logic [NUM_TYPES-1:0] mism1;
  logic [NUM_TYPES-1:0] mism2;
  logic [NUM_TYPES-1:0] mask2;
  logic [23:0]          blocks_ext;
  logic [7:0]           count_inc;

  assign is_space = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
  assign blocks_ext = {8'd0, st.line_blocks};
  assign count_inc = (st.name_count == 8'hff) ? st.name_count : st.name_count + 8'd1;

  always_comb begin
    for (int i = 0; i < NUM_TYPES; i++) begin
      mism0[i] = TYPE_NAMES[i][0] != data_byte;
      mism1[i] = TYPE_NAMES[i][1] != data_byte;
      mism2[i] = TYPE_NAMES[i][2] != data_byte;
    end
  end

  always_comb begin
    st = first_byte ? STATE_RESET : cur;
    nxt = st;
    res_valid = 1'b0;
    res = '0;
    mask2 = st.type_match_mask & ~mism2;
    priority if (st.phase == PH_DONE) begin
      nxt = st;
    end else if (st.phase >= PH_TEXT0 && data_byte == 8'd0) begin
      // end of line record
      res_valid = 1'b1;
      res.kind = (st.phase <= PH_POSTSTAR) ? KIND_ERROR : KIND_LINE;
      res.block_count = st.line_blocks;
      res.size_bytes = blocks_ext * BLOCK_DATA_BYTES;
      res.entry_type = st.line_type;
      res.not_closed = st.unclosed_mark;
      res.read_only = st.lock_mark;
      res.name_length = st.name_count;
      nxt.phase = PH_LINK_LO;
    end else begin
      unique case (st.phase)
        PH_LINK_LO: begin
          nxt.link_low_nonzero = data_byte != 8'd0;
          nxt.phase = PH_LINK_HI;
        end
        PH_LINK_HI: begin
          if (!st.link_low_nonzero && data_byte == 8'd0) begin
            nxt.phase = PH_DONE;
            res_valid = 1'b1;
            res.kind = KIND_END;
            res.is_last = 1'b1;
          end else begin
            nxt.phase = PH_BLK_LO;
          end
        end
        PH_BLK_LO: begin
          nxt.line_blocks = {8'd0, data_byte};
          nxt.phase = PH_BLK_HI;
        end
        PH_BLK_HI: begin
          nxt = STATE_RESET;
          nxt.link_low_nonzero = st.link_low_nonzero;
          nxt.line_blocks = {data_byte, st.line_blocks[7:0]};
          nxt.phase = PH_TEXT0;
        end
        PH_TEXT0, PH_LEAD: begin
          if (st.phase == PH_TEXT0 && data_byte == HEADER_MARK && st.line_blocks == 16'd0) begin
            nxt.line_type = T_HEADER;
          end
          if (is_space) begin
            nxt.phase = PH_LEAD;
          end else if (data_byte == CH_QUOTE) begin
            nxt.line_type = T_UNKNOWN;
            nxt.phase = PH_NAME;
          end else begin
            if (data_byte == CH_B) begin
              nxt.line_type = T_BFREE;
            end
            nxt.phase = PH_REST;
          end
        end
        PH_NAME: begin
          if (data_byte == CH_QUOTE) begin
            nxt.phase = PH_POSTNAME;
          end else begin
            nxt.name_count = count_inc;
            res_valid = 1'b1;
            res.kind = KIND_NAME;
            res.name_char = data_byte;
            res.name_length = count_inc;
          end
        end
        PH_POSTNAME: begin
          if (is_space) begin
            nxt.phase = PH_POSTNAME;
          end else if (data_byte == CH_STAR) begin
            nxt.unclosed_mark = 1'b1;
            nxt.phase = PH_POSTSTAR;
          end else begin
            nxt.type_match_mask = st.type_match_mask & ~mism0;
            nxt.phase = PH_TYPE1;
          end
        end
        PH_POSTSTAR: begin
          nxt.type_match_mask = st.type_match_mask & ~mism0;
          nxt.phase = PH_TYPE1;
        end
        PH_TYPE1: begin
          nxt.type_match_mask = st.type_match_mask & ~mism1;
          nxt.phase = PH_TYPE2;
        end
        PH_TYPE2: begin
          nxt.type_match_mask = mask2;
          nxt.phase = (mask2 != '0) ? PH_LOCK : PH_REST;
          // lowest matching name wins
          for (int i = NUM_TYPES - 1; i >= 0; i--) begin
            if (mask2[i]) begin
              nxt.line_type = T_TYPE_BASE + 4'(i);
            end
          end
        end
        PH_LOCK: begin
          if (data_byte == CH_LOCK) begin
            nxt.lock_mark = 1'b1;
          end
          nxt.phase = PH_REST;
        end
        PH_REST, PH_TYPE0: begin
          nxt.phase = st.phase;
        end
        default: begin
          nxt.phase = PH_REST;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/disk_directory_line_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// a result is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle while rec_out is not stalled, the parse state updates in a single step per byte
// the output register takes a new result while the previous one leaves in the same cycle
// reset (rst, synchronous) returns the parser to the link low byte and empties the output
module disk_directory_line_parser_core (
  input  logic       clk,
  input  logic       rst,
  ddlp_byte_if.sink  byte_in,
  ddlp_rec_if.source rec_out
);
  import ddlp_pkg::*;

  state_t  state;
  state_t  state_next;
  logic    res_valid;
  result_t res;
  result_t out_reg;
  logic    out_valid;
  logic    accept;

  ddlp_step u_step (
    .cur        (state),
    .data_byte  (byte_in.data_byte),
    .first_byte (byte_in.first_byte),
    .nxt        (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign byte_in.ready = !out_valid || rec_out.ready;
  assign accept = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        out_valid <= res_valid;
      end else if (rec_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_reg <= res;
    end
  end

  assign rec_out.valid       = out_valid;
  assign rec_out.kind        = out_reg.kind;
  assign rec_out.name_char   = out_reg.name_char;
  assign rec_out.block_count = out_reg.block_count;
  assign rec_out.size_bytes  = out_reg.size_bytes;
  assign rec_out.entry_type  = out_reg.entry_type;
  assign rec_out.not_closed  = out_reg.not_closed;
  assign rec_out.read_only   = out_reg.read_only;
  assign rec_out.name_length = out_reg.name_length;
  assign rec_out.is_last     = out_reg.is_last;

endmodule
`default_nettype wire

// File: src/ddlp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ddlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] block_count,
  input logic [23:0] size_bytes,
  input logic [3:0]  entry_type,
  input logic [7:0]  name_length,
  input logic        is_last
);
  import ddlp_pkg::*;

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled transaction dropped");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_last || kind == KIND_END) |-> is_last && kind == KIND_END
      && name_length == 8'd0)
    else $error("end of listing marking mismatch");

  a_name_no_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NAME |-> block_count == 16'd0 && size_bytes == 24'd0
      && entry_type == T_HEADER && name_length != 8'd0)
    else $error("name character carries line fields");

endmodule

bind disk_directory_line_parser_core ddlp_checker u_ddlp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (byte_in.ready),
  .out_valid   (rec_out.valid),
  .out_ready   (rec_out.ready),
  .kind        (rec_out.kind),
  .block_count (rec_out.block_count),
  .size_bytes  (rec_out.size_bytes),
  .entry_type  (rec_out.entry_type),
  .name_length (rec_out.name_length),
  .is_last     (rec_out.is_last)
);
`default_nettype wire
